/* rtl/hfe_pkg.sv */
// Shared types, constants and CRC/hex helpers for the hex frame encoder.
package hfe_pkg;

  localparam int unsigned HFE_FIFO_DEPTH = 4;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic [7:0]  CHAR_BANG = 8'h21;
  localparam logic [7:0]  CHAR_NL   = 8'h0A;

  localparam logic [7:0]  CRC8_POLY  = 8'h07;
  localparam logic [7:0]  CRC8_INIT  = 8'h00;
  localparam logic [15:0] CRC16_POLY = 16'h1021;
  localparam logic [15:0] CRC16_INIT = 16'hFFFF;

  // Character positions within a frame; payload jobs start at POS_DATA_HI.
  localparam logic [3:0] POS_BANG    = 4'd0;
  localparam logic [3:0] POS_TYPE_HI = 4'd1;
  localparam logic [3:0] POS_TYPE_LO = 4'd2;
  localparam logic [3:0] POS_LEN_HI  = 4'd3;
  localparam logic [3:0] POS_LEN_LO  = 4'd4;
  localparam logic [3:0] POS_DATA_HI = 4'd5;
  localparam logic [3:0] POS_DATA_LO = 4'd6;
  localparam logic [3:0] POS_CRCL_HI = 4'd7;
  localparam logic [3:0] POS_CRCL_LO = 4'd8;
  localparam logic [3:0] POS_CRCH_HI = 4'd9;
  localparam logic [3:0] POS_CRCH_LO = 4'd10;
  localparam logic [3:0] POS_NL      = 4'd11;

  // One queued job: header (b0 type, b1 len, b2 header crc) or payload (b2 data).
  typedef struct packed {
    logic        is_hdr;
    logic        trailer;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [15:0] crc;
  } hfe_job_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC8_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC16_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'h0, n};
    end else begin
      c = 8'h37 + {4'h0, n};
    end
    return c;
  endfunction

endpackage

/* rtl/hfe_front.sv */
// Front end: accepts input beats, tracks frame state and CRC-16, emits jobs.
module hfe_front
  import hfe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_cmd_i,
  input  logic [7:0] in_type_i,
  input  logic [7:0] in_len_i,
  input  logic [7:0] in_data_i,
  input  logic     q_full_i,
  output logic     in_ready_o,
  output logic     push_o,
  output hfe_job_t job_o
);

  logic        open_q, open_d;
  logic [7:0]  left_q, left_d;
  logic [15:0] crc_q, crc_d;
  logic        accept;
  logic [15:0] crc_next;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign crc_next   = crc16_byte(crc_q, in_data_i);

  always_comb begin
    open_d = open_q;
    left_d = left_q;
    crc_d  = crc_q;
    push_o = 1'b0;
    job_o  = '0;
    if (accept) begin
      if (in_cmd_i == CMD_START) begin
        push_o       = 1'b1;
        crc_d        = CRC16_INIT;
        left_d       = in_len_i;
        open_d       = (in_len_i != 8'd0);
        job_o.is_hdr = 1'b1;
        job_o.trailer = (in_len_i == 8'd0);
        job_o.b0     = in_type_i;
        job_o.b1     = in_len_i;
        job_o.b2     = crc8_byte(crc8_byte(CRC8_INIT, in_type_i), in_len_i);
        job_o.crc    = CRC16_INIT;
      end else if (open_q) begin
        push_o        = 1'b1;
        crc_d         = crc_next;
        left_d        = left_q - 8'd1;
        open_d        = (left_q != 8'd1);
        job_o.is_hdr  = 1'b0;
        job_o.trailer = (left_q == 8'd1);
        job_o.b2      = in_data_i;
        job_o.crc     = crc_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= 8'd0;
      crc_q  <= CRC16_INIT;
    end else begin
      open_q <= open_d;
      left_q <= left_d;
      crc_q  <= crc_d;
    end
  end

endmodule

/* rtl/hfe_fifo.sv */
// Short job queue between front and back end; its head is read combinationally.
module hfe_fifo
  import hfe_pkg::*;
#(
  parameter int unsigned DEPTH = HFE_FIFO_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hfe_job_t job_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     empty_o,
  output hfe_job_t head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  hfe_job_t       mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("job queue underflow");

endmodule

/* rtl/hfe_back.sv */
// Back end: walks each queued job and emits its characters into an output register.
module hfe_back
  import hfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  hfe_job_t   head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  logic [3:0] idx_q, idx_d;
  logic [3:0] pos, end_pos;
  logic       step;
  logic [7:0] ch;
  logic       valid_q;
  logic [7:0] char_q;
  logic       last_q;

  assign pos     = head_i.is_hdr ? idx_q : idx_q + POS_DATA_HI;
  assign end_pos = head_i.trailer ? POS_NL : POS_DATA_LO;
  assign step    = !empty_i && (!valid_q || out_ready_i);
  assign pop_o   = step && (pos == end_pos);
  assign idx_d   = pop_o ? 4'd0 : idx_q + 4'd1;

  always_comb begin
    case (pos)
      POS_BANG:    ch = CHAR_BANG;
      POS_TYPE_HI: ch = hex_char(head_i.b0[7:4]);
      POS_TYPE_LO: ch = hex_char(head_i.b0[3:0]);
      POS_LEN_HI:  ch = hex_char(head_i.b1[7:4]);
      POS_LEN_LO:  ch = hex_char(head_i.b1[3:0]);
      POS_DATA_HI: ch = hex_char(head_i.b2[7:4]);
      POS_DATA_LO: ch = hex_char(head_i.b2[3:0]);
      POS_CRCL_HI: ch = hex_char(head_i.crc[7:4]);
      POS_CRCL_LO: ch = hex_char(head_i.crc[3:0]);
      POS_CRCH_HI: ch = hex_char(head_i.crc[15:12]);
      POS_CRCH_LO: ch = hex_char(head_i.crc[11:8]);
      POS_NL:      ch = CHAR_NL;
      default:     ch = CHAR_NL;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      char_q <= ch;
      last_q <= (pos == POS_NL);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 4'd0;
      valid_q <= 1'b0;
    end else begin
      if (step) begin
        idx_q   <= idx_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  a_last_is_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |-> (char_q == CHAR_NL))
    else $error("tlast on a character other than newline");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (pos <= end_pos))
    else $error("character position past end of job");

endmodule

/* rtl/hex_frame_encoder_crc.sv */
// Top level of the ASCII-hex frame encoder with CRC-8 header and CRC-16 trailer.
//
// channel   dir  tdata                                         tuser    tlast
// s_axis    in   [7:0] frame_type [15:8] payload_len            command  -
//                [23:16] data_byte
// m_axis    out  [7:0] out_char                                 -        last
//
// One beat in per cycle while the job queue has room; one character out per cycle
// while the receiver is ready and a job is queued. A payload beat makes 2 characters
// (7 when it closes the frame), a start beat 7 (12 with zero length), so sustained
// input is limited by the single-character output register that follows the queue.
// Reset clears frame state, the queue and the output valid; no clearing pass.
// Output stalls back up into the queue; input stalls only when the queue is full.
module hex_frame_encoder_crc
  import hfe_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = HFE_FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // frame_type, payload_len, data_byte
  input  logic        s_axis_tuser_i,  // command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // out_char
  output logic        m_axis_tlast_o
);

  hfe_job_t push_job, head_job;
  logic     push, pop, full, empty;

  hfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_cmd_i   (s_axis_tuser_i),
    .in_type_i  (s_axis_tdata_i[7:0]),
    .in_len_i   (s_axis_tdata_i[15:8]),
    .in_data_i  (s_axis_tdata_i[23:16]),
    .q_full_i   (full),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push),
    .job_o      (push_job)
  );

  hfe_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head_job)
  );

  hfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

/* sim/tb.sv */
// Testbench for hex_frame_encoder_crc: directed and random framed traffic checked against a frame predictor.
module tb
  import hfe_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 255;
  localparam int HOLD_CYCLES  = 150;
  localparam int HOLD_AT_BEAT = 200;
  localparam int IDLE_LIMIT   = 1000;
  localparam int TAIL_CYCLES  = 20;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } frame_char_t;

  class frame_scoreboard;
    frame_char_t char_q[$];
    string       hex_digits = "0123456789ABCDEF";
    logic [15:0] body_crc;
    logic [7:0]  bytes_due;
    bit          frame_open;
    int          errors;

    function new();
      body_crc   = CRC16_INIT;
      bytes_due  = 8'd0;
      frame_open = 1'b0;
      errors     = 0;
    endfunction

    function logic [7:0] header_crc8(logic [7:0] ftype, logic [7:0] len);
      logic [15:0] hdr;
      logic [7:0]  c;
      logic        fb;
      hdr = {ftype, len};
      c   = CRC8_INIT;
      for (int i = 15; i >= 0; i--) begin
        fb = c[7] ^ hdr[i];
        c  = {c[6:0], 1'b0};
        if (fb) c = c ^ CRC8_POLY;
      end
      return c;
    endfunction

    function logic [15:0] payload_crc16(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0};
        if (fb) c = c ^ CRC16_POLY;
      end
      return c;
    endfunction

    function void push_char(logic [7:0] ch, logic last);
      frame_char_t c;
      c.ch   = ch;
      c.last = last;
      char_q.push_back(c);
    endfunction

    function void push_hex(logic [7:0] b);
      push_char(hex_digits[b[7:4]], 1'b0);
      push_char(hex_digits[b[3:0]], 1'b0);
    endfunction

    function void push_trailer();
      push_hex(body_crc[7:0]);
      push_hex(body_crc[15:8]);
      push_char(CHAR_NL, 1'b1);
    endfunction

    function void note_beat(logic cmd, logic [7:0] ftype, logic [7:0] len, logic [7:0] data);
      if (cmd == CMD_START) begin
        body_crc  = CRC16_INIT;
        bytes_due = len;
        push_char(CHAR_BANG, 1'b0);
        push_hex(ftype);
        push_hex(len);
        push_hex(header_crc8(ftype, len));
        frame_open = (len != 8'd0);
        if (len == 8'd0) push_trailer();
      end else if (frame_open) begin
        push_hex(data);
        body_crc  = payload_crc16(body_crc, data);
        bytes_due = bytes_due - 8'd1;
        if (bytes_due == 8'd0) begin
          push_trailer();
          frame_open = 1'b0;
        end
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      frame_char_t w;
      if (char_q.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got char %h last %b", $time, ch, last);
        errors++;
        return;
      end
      w = char_q.pop_front();
      if (ch !== w.ch) begin
        $display("%0t: char mismatch: expected %h, got %h", $time, w.ch, ch);
        errors++;
      end
      if (last !== w.last) begin
        $display("%0t: last mismatch: expected %b, got %b", $time, w.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return char_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = 24'd0;  // frame_type, payload_len, data_byte
  logic        s_tuser  = 1'b0;   // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // out_char
  logic        m_tlast;

  bit              tx_calm = 1'b0;
  bit              rx_calm = 1'b0;
  int              idle_cycles = 0;
  frame_scoreboard frame_sb = new();

  hex_frame_encoder_crc u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic cmd, input logic [7:0] ftype, input logic [7:0] len,
                           input logic [7:0] data);
    int gap;
    gap = tx_calm ? 0 : int'($urandom_range(0, 5));
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {data, len, ftype};
    s_tuser  <= cmd;
    do @(posedge clk_i); while (!s_tready);
    frame_sb.note_beat(cmd, ftype, len, data);
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] len, input int nbytes);
    send_beat(CMD_START, ftype, len, 8'($urandom));
    for (int i = 0; i < nbytes; i++) begin
      send_beat(CMD_DATA, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // receiver: random stalls, calm stretches, one long hold-off to back up the queue
  initial begin : rx_proc
    int gap;
    int beats;
    beats = 0;
    wait (rst_n);
    @(posedge clk_i);
    forever begin
      if (beats % 48 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      gap = rx_calm ? 0 : int'($urandom_range(0, 5));
      if (beats == HOLD_AT_BEAT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      frame_sb.check_char(m_tdata, m_tlast);
      beats++;
    end
  end

  initial begin : stim_proc
    int         counted;
    int         pick;
    int         nbytes;
    logic [7:0] ftype;
    logic [7:0] len;
    counted = 0;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // payload with no frame open
    send_beat(CMD_DATA, 8'h00, 8'h00, 8'h5A);
    // zero length, type extremes
    send_beat(CMD_START, 8'h00, 8'h00, 8'hFF);
    send_beat(CMD_START, 8'hFF, 8'h00, 8'h00);
    send_beat(CMD_START, 8'hA5, 8'h01, 8'h00);
    send_beat(CMD_DATA, 8'hFF, 8'hFF, 8'hFF);
    send_beat(CMD_START, 8'h3C, 8'h02, 8'h00);
    send_beat(CMD_DATA, 8'h00, 8'h00, 8'h00);
    send_beat(CMD_DATA, 8'h00, 8'h00, 8'h80);
    // stray payload after a closed frame
    send_beat(CMD_DATA, 8'hFF, 8'hFF, 8'hFF);
    // open frames abandoned by a new start
    send_beat(CMD_START, 8'h01, 8'hFF, 8'h00);
    send_beat(CMD_DATA, 8'h00, 8'h00, 8'h12);
    send_beat(CMD_DATA, 8'h00, 8'h00, 8'h34);
    send_beat(CMD_START, 8'h7E, 8'h03, 8'h00);
    send_beat(CMD_DATA, 8'h00, 8'h00, 8'hC3);
    send_beat(CMD_START, 8'h10, 8'h00, 8'h00);

    while (counted < RANDOM_ITEMS) begin
      pick    = int'($urandom_range(0, 15));
      tx_calm = ($urandom_range(0, 3) == 0);
      ftype   = 8'($urandom);
      if (pick == 0) begin
        len = 8'd0;
      end else if (pick == 1) begin
        len = 8'($urandom);
      end else begin
        len = 8'($urandom_range(1, 8));
      end
      nbytes = int'(len);
      if (nbytes > 24) begin
        nbytes = int'($urandom_range(0, 24));
      end else if ($urandom_range(0, 5) == 0) begin
        nbytes = int'($urandom_range(0, nbytes));
      end
      send_frame(ftype, len, nbytes);
      counted += 1 + nbytes;
      if ($urandom_range(0, 7) == 0) begin
        send_beat(CMD_DATA, 8'($urandom), 8'($urandom), 8'($urandom));
        if (nbytes < int'(len)) counted++;
      end
    end
    s_tvalid <= 1'b0;

    while (frame_sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (frame_sb.errors == 0 && frame_sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hfe_pkg.sv
rtl/hfe_front.sv
rtl/hfe_fifo.sv
rtl/hfe_back.sv
rtl/hex_frame_encoder_crc.sv
sim/tb.sv
